// File: sv/ddo_pkg.sv
// ----------------------------------------------------------------------------
// Differential drive odometry package
// Shared widths, fixed-point constants, register indexes and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

	// Number of CORDIC rotations; sine and cosine carry this many fraction bits.
	localparam int TRIG_BITS = 16;

	localparam int COUNT_W   = 16;
	localparam int GAIN_W    = 24;
	localparam int POS_W     = 32;
	localparam int HEAD_W    = 32;
	localparam int HEADOUT_W = 16;
	localparam int CFG_IDX_W = 8;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_DIST_GAIN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN = CFG_IDX_W'(1);

	localparam logic [GAIN_W-1:0] DIST_GAIN_RESET = GAIN_W'(71904);
	localparam logic [GAIN_W-1:0] TURN_GAIN_RESET = GAIN_W'(26657);

	localparam int ATAN_IDX_W = 5;

	typedef logic signed [COUNT_W-1:0]   count_t;
	typedef logic signed [POS_W-1:0]     pos_t;
	typedef logic        [HEADOUT_W-1:0] head_out_t;
	typedef logic        [GAIN_W-1:0]    gain_t;
	typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

	// Arctangent of 2^-i in Q30 radians.
	function automatic logic [31:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:    v = 32'h3243F6A8;
			5'd1:    v = 32'h1DAC6705;
			5'd2:    v = 32'h0FADBAFC;
			5'd3:    v = 32'h07F56EA6;
			5'd4:    v = 32'h03FEAB76;
			5'd5:    v = 32'h01FFD55B;
			5'd6:    v = 32'h00FFFAAA;
			5'd7:    v = 32'h007FFF55;
			5'd8:    v = 32'h003FFFEA;
			5'd9:    v = 32'h001FFFFD;
			5'd10:   v = 32'h000FFFFF;
			5'd11:   v = 32'h0007FFFF;
			5'd12:   v = 32'h0003FFFF;
			5'd13:   v = 32'h0001FFFF;
			5'd14:   v = 32'h0000FFFF;
			5'd15:   v = 32'h00007FFF;
			5'd16:   v = 32'h00003FFF;
			5'd17:   v = 32'h00001FFF;
			5'd18:   v = 32'h00000FFF;
			5'd19:   v = 32'h000007FF;
			5'd20:   v = 32'h000003FF;
			5'd21:   v = 32'h000001FF;
			5'd22:   v = 32'h000000FF;
			5'd23:   v = 32'h0000007F;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

// File: sv/ddo_if.sv
// ----------------------------------------------------------------------------
// Differential drive odometry channels
// Valid/ready interfaces for the encoder tick input, the pose output and the
// configuration write channel.
// ----------------------------------------------------------------------------
interface ddo_tick_if;
	import ddo_pkg::*;
	logic   valid;
	logic   ready;
	count_t left_count;
	count_t right_count;
	modport source (output valid, output left_count, output right_count, input ready);
	modport sink   (input valid, input left_count, input right_count, output ready);
endinterface

interface ddo_pose_if;
	import ddo_pkg::*;
	logic      valid;
	logic      ready;
	pos_t      pos_x;
	pos_t      pos_y;
	head_out_t heading_out;
	modport source (output valid, output pos_x, output pos_y, output heading_out, input ready);
	modport sink   (input valid, input pos_x, input pos_y, input heading_out, output ready);
endinterface

interface ddo_cfg_if;
	import ddo_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	gain_t    data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// Differential drive odometry
// Keeps the robot pose (x, y, heading) from per-tick wheel encoder counts,
// using one shared multiplier and an iterative CORDIC under a sequencer.
// ----------------------------------------------------------------------------
// Usage:
// The ticks channel carries one word per control tick: the signed left and
// right encoder count changes. The pose channel returns one word per tick:
// the updated x and y position (2^-16 mm) and the top 16 bits of the heading.
// The cfg channel writes dist_gain (index 0) and turn_gain (index 1); other
// indexes are ignored. It is always ready and should be used only while the
// block is idle.
// From the accepting edge the sequencer runs the fold, travel, turn and
// heading steps, the CORDIC loop at one rotation per cycle on a single
// shift-add unit, rounding, the products on the shared multiplier, the
// position sum and the final step. A new tick word is taken only once the
// previous one has passed its final step and the sequencer is back in its
// idle step, so no new word is taken while one is in flight.
// The result sits in an output register, so the next tick is accepted while
// the receiver stalls; the sequencer waits in its final step only when a
// finished pose would overwrite one not yet taken.
// Reset clears the pose to zero, restores the gain defaults and empties the
// output register.
// ----------------------------------------------------------------------------
module differential_drive_odometry (
	input  logic clk,
	input  logic arst_n,
	ddo_tick_if.sink   ticks,
	ddo_pose_if.source pose,
	ddo_cfg_if.sink    cfg
);
	import ddo_pkg::*;

	// Sequencer steps.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MAG  = 4'd1;  // fold heading, multiply by pi/2
	localparam logic [3:0] S_TRAV = 4'd2;  // angle into z, multiply travel
	localparam logic [3:0] S_TURN = 4'd3;  // round travel, multiply turn
	localparam logic [3:0] S_HEAD = 4'd4;  // add turn to heading
	localparam logic [3:0] S_ROT  = 4'd5;  // CORDIC rotations
	localparam logic [3:0] S_RND  = 4'd6;  // round sine and cosine
	localparam logic [3:0] S_MULX = 4'd7;
	localparam logic [3:0] S_MULY = 4'd8;
	localparam logic [3:0] S_SUM  = 4'd9;  // saturating position update
	localparam logic [3:0] S_DONE = 4'd10; // hand the pose to the output register

	// The CORDIC datapath works in Q30 with a little headroom.
	localparam int CW      = 34;
	localparam int SH      = 30 - TRIG_BITS;
	localparam int TRIG_W  = TRIG_BITS + 2;
	localparam int ITER_W  = $clog2(TRIG_BITS);
	localparam int SUM_W   = COUNT_W + 1;
	localparam int TRAV_W  = SUM_W + GAIN_W;
	localparam int T16_W   = TRAV_W - 8;
	localparam int MA_W    = 34;
	localparam int MB_W    = 32;
	localparam int PROD_W  = MA_W + MB_W;
	localparam int DX_W    = 35;
	localparam int ACC_W   = DX_W + 1;

	localparam logic signed [CW-1:0]   CORDIC_K   = CW'(652032874);
	localparam logic signed [MB_W-1:0] HALF_PI    = MB_W'(1686629713);
	localparam logic signed [CW-1:0]   TRIG_HALF  = CW'(1) <<< (SH - 1);
	localparam logic signed [PROD_W-1:0] DX_HALF  = PROD_W'(1) <<< (TRIG_BITS - 1);
	localparam logic [ITER_W-1:0]      ITER_LAST  = ITER_W'(TRIG_BITS - 1);
	localparam logic signed [ACC_W-1:0] POS_MAX   = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] POS_MIN   = -ACC_W'(64'sd2147483648);

	logic [3:0] state_q;

	gain_t dist_gain_q;
	gain_t turn_gain_q;

	pos_t              x_pos_q;
	pos_t              y_pos_q;
	logic [HEAD_W-1:0] heading_q;

	logic signed [SUM_W-1:0]  sum_q;
	logic signed [SUM_W-1:0]  diff_q;
	logic                     neg_q;
	logic                     flip_q;
	logic signed [CW-1:0]     cx_q;
	logic signed [CW-1:0]     cy_q;
	logic signed [CW-1:0]     z_q;
	logic [ITER_W-1:0]        iter_q;
	logic signed [T16_W-1:0]  t16_q;
	logic signed [TRIG_W-1:0] cos_q;
	logic signed [TRIG_W-1:0] sin_q;
	logic signed [DX_W-1:0]   dx_q;
	logic signed [PROD_W-1:0] prod_q;

	logic      out_valid_q;
	pos_t      out_x_q;
	pos_t      out_y_q;
	head_out_t out_head_q;

	// Heading folded into [-1/4, 1/4] turn, with the half-turn flip noted.
	logic signed [HEAD_W:0] ang_raw;
	logic signed [HEAD_W:0] ang_fold;
	logic                   ang_flip;
	logic [HEAD_W-1:0]      ang_mag;

	always_comb begin
		ang_raw  = (HEAD_W+1)'($signed(heading_q));
		ang_fold = ang_raw;
		ang_flip = 1'b0;
		if (ang_raw > 33'sh0_4000_0000) begin
			ang_fold = ang_raw - 33'sh0_8000_0000;
			ang_flip = 1'b1;
		end else if (ang_raw < -33'sh0_4000_0000) begin
			ang_fold = ang_raw + 33'sh0_8000_0000;
			ang_flip = 1'b1;
		end
		ang_mag = ang_fold[HEAD_W] ? HEAD_W'(-ang_fold) : HEAD_W'(ang_fold);
	end

	// The one shared multiplier; its operands follow the sequencer step.
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MAG: begin
				mul_a = MA_W'($signed({1'b0, ang_mag}));
				mul_b = HALF_PI;
			end
			S_TRAV: begin
				mul_a = MA_W'(sum_q);
				mul_b = MB_W'($signed({1'b0, dist_gain_q}));
			end
			S_TURN: begin
				mul_a = MA_W'(diff_q);
				mul_b = MB_W'($signed({1'b0, turn_gain_q}));
			end
			S_MULX: begin
				mul_a = MA_W'(t16_q);
				mul_b = MB_W'(cos_q);
			end
			S_MULY: begin
				mul_a = MA_W'(t16_q);
				mul_b = MB_W'(sin_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Shared shift-add unit for one CORDIC rotation.
	logic signed [CW-1:0] rot_dx;
	logic signed [CW-1:0] rot_dy;
	logic signed [CW-1:0] rot_atan;

	assign rot_dx   = cy_q >>> iter_q;
	assign rot_dy   = cx_q >>> iter_q;
	assign rot_atan = CW'($signed({1'b0, atan_q30(ATAN_IDX_W'(iter_q))}));

	// Rounding of the CORDIC outputs and of the position deltas.
	logic signed [CW-1:0]     cx_rnd;
	logic signed [CW-1:0]     cy_rnd;
	logic signed [TRIG_W-1:0] cos_rnd;
	logic signed [TRIG_W-1:0] sin_rnd;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [DX_W-1:0]   dy_now;
	logic signed [ACC_W-1:0]  x_next;
	logic signed [ACC_W-1:0]  y_next;
	logic signed [TRAV_W:0]   trav_rnd;
	logic signed [CW-1:0]     z_mag;

	always_comb begin
		cx_rnd   = (cx_q + TRIG_HALF) >>> SH;
		cy_rnd   = (cy_q + TRIG_HALF) >>> SH;
		cos_rnd  = flip_q ? -TRIG_W'(cx_rnd) : TRIG_W'(cx_rnd);
		sin_rnd  = flip_q ? -TRIG_W'(cy_rnd) : TRIG_W'(cy_rnd);
		prod_rnd = (prod_q + DX_HALF) >>> TRIG_BITS;
		dy_now   = DX_W'(prod_rnd);
		x_next   = ACC_W'(x_pos_q) + ACC_W'(dx_q);
		y_next   = ACC_W'(y_pos_q) + ACC_W'(dy_now);
		trav_rnd = (TRAV_W+1)'(prod_q[TRAV_W-1:0]) + (TRAV_W+1)'(128);
		z_mag    = CW'(prod_q >>> 30);
	end

	function automatic pos_t sat_pos(input logic signed [ACC_W-1:0] v);
		pos_t r;
		if (v > POS_MAX)
			r = POS_MAX[POS_W-1:0];
		else if (v < POS_MIN)
			r = POS_MIN[POS_W-1:0];
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

	logic out_free;
	assign out_free = !out_valid_q || pose.ready;

	assign ticks.ready = (state_q == S_IDLE);
	assign cfg.ready   = 1'b1;

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			iter_q      <= '0;
			dist_gain_q <= DIST_GAIN_RESET;
			turn_gain_q <= TURN_GAIN_RESET;
			x_pos_q     <= '0;
			y_pos_q     <= '0;
			heading_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					REG_DIST_GAIN: dist_gain_q <= cfg.data;
					REG_TURN_GAIN: turn_gain_q <= cfg.data;
					default: ;
				endcase
			end

			// A finished pose loads the output register; otherwise a taken word
			// empties it.
			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (pose.ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: if (ticks.valid) state_q <= S_MAG;
				S_MAG:  state_q <= S_TRAV;
				S_TRAV: state_q <= S_TURN;
				S_TURN: state_q <= S_HEAD;
				S_HEAD: begin
					heading_q <= heading_q + prod_q[HEAD_W-1:0];
					iter_q    <= '0;
					state_q   <= S_ROT;
				end
				S_ROT: begin
					iter_q <= iter_q + ITER_W'(1);
					if (iter_q == ITER_LAST)
						state_q <= S_RND;
				end
				S_RND:  state_q <= S_MULX;
				S_MULX: state_q <= S_MULY;
				S_MULY: state_q <= S_SUM;
				S_SUM: begin
					x_pos_q <= sat_pos(x_next);
					y_pos_q <= sat_pos(y_next);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				sum_q  <= SUM_W'(ticks.left_count) + SUM_W'(ticks.right_count);
				diff_q <= SUM_W'(ticks.right_count) - SUM_W'(ticks.left_count);
			end
			S_MAG: begin
				neg_q  <= ang_fold[HEAD_W];
				flip_q <= ang_flip;
			end
			S_TRAV: begin
				z_q  <= neg_q ? -z_mag : z_mag;
				cx_q <= CORDIC_K;
				cy_q <= '0;
			end
			S_TURN: t16_q <= T16_W'(trav_rnd >>> 8);
			S_ROT: begin
				if (!z_q[CW-1]) begin
					cx_q <= cx_q - rot_dx;
					cy_q <= cy_q + rot_dy;
					z_q  <= z_q - rot_atan;
				end else begin
					cx_q <= cx_q + rot_dx;
					cy_q <= cy_q - rot_dy;
					z_q  <= z_q + rot_atan;
				end
			end
			S_RND: begin
				cos_q <= cos_rnd;
				sin_q <= sin_rnd;
			end
			S_MULY: dx_q <= DX_W'(prod_rnd);
			S_DONE: begin
				if (out_free) begin
					out_x_q    <= x_pos_q;
					out_y_q    <= y_pos_q;
					out_head_q <= heading_q[HEAD_W-1:HEAD_W-HEADOUT_W];
				end
			end
			default: ;
		endcase
	end

	assign pose.valid       = out_valid_q;
	assign pose.pos_x       = out_x_q;
	assign pose.pos_y       = out_y_q;
	assign pose.heading_out = out_head_q;

`ifndef SYNTHESIS
	// An accepted tick always starts the sequence at the fold step.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		ticks.valid && ticks.ready |=> state_q == S_MAG)
		else $error("accepted tick did not start the sequencer");

	// A new pose word appears only out of the final step.
	a_pose_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("pose word loaded outside the final step");

	// The final step never overwrites a pose that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && out_valid_q && !pose.ready |=> state_q == S_DONE)
		else $error("pending pose word overwritten");

	// The rotation count restarts at zero on entry to the CORDIC loop.
	a_iter_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_HEAD |=> state_q == S_ROT && iter_q == '0)
		else $error("CORDIC loop entered with a stale rotation count");
`endif

endmodule
